// ===== rtl/ati_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ati_pkg: shared constants and types for the attenuation table interpolator
// Breakpoint, coefficient and per-segment reciprocal tables, widths and the
// stage-enable bundle used by the coefficient blend pipeline.
// ----------------------------------------------------------------------------
package ati_pkg;

  localparam int DIST_FRAC_BITS = 8;
  localparam int COEF_FRAC_BITS = 30;
  localparam int ROWS           = 12;
  localparam int SEGS           = ROWS - 1;

  localparam int DIST_W  = 20;
  localparam int COEF_W  = 31;
  localparam int BP_W    = 12;
  localparam int SEG_W   = 4;
  localparam int RECIP_W = 30;
  // offset * reciprocal stays below 256 * (2^32 + span) inside a segment
  localparam int PROD_W  = 41;
  localparam int T_BITS  = 24;
  localparam int T_W     = T_BITS + 1;
  localparam int MUL_W   = COEF_W + T_W;

  localparam logic [T_W-1:0]    T_ONE    = T_W'(1) << T_BITS;
  localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(1) << COEF_FRAC_BITS;

  typedef enum logic [1:0] {
    COL_CONST = 2'd0,
    COL_LIN   = 2'd1,
    COL_QUAD  = 2'd2
  } coef_col_t;

  // breakpoints in whole distance units
  localparam logic [0:ROWS-1][BP_W-1:0] BP_WHOLE = '{
    12'd7, 12'd13, 12'd20, 12'd32, 12'd50, 12'd65,
    12'd100, 12'd160, 12'd200, 12'd325, 12'd600, 12'd3250
  };

  // round-half-up Q1.30 coefficients: constant, linear, quadratic
  localparam logic [0:ROWS-1][0:2][COEF_W-1:0] COEF_Q = '{
    '{31'd1073741824, 31'd751619277, 31'd1932735283},
    '{31'd1073741824, 31'd375809638, 31'd472446403},
    '{31'd1073741824, 31'd236223201, 31'd214748365},
    '{31'd1073741824, 31'd150323855, 31'd75161928},
    '{31'd1073741824, 31'd96636764,  31'd34359738},
    '{31'd1073741824, 31'd75161928,  31'd18253611},
    '{31'd1073741824, 31'd48318382,  31'd8053064},
    '{31'd1073741824, 31'd28991029,  31'd3006477},
    '{31'd1073741824, 31'd23622320,  31'd2040109},
    '{31'd1073741824, 31'd15032386,  31'd751619},
    '{31'd1073741824, 31'd7516193,   31'd214748},
    '{31'd1073741824, 31'd1503239,   31'd7516}
  };

  // round(2^32 / span) per segment
  localparam logic [0:SEGS-1][RECIP_W-1:0] RECIP = '{
    30'd715827883, 30'd613566757, 30'd357913941, 30'd238609294,
    30'd286331153, 30'd122713351, 30'd71582788,  30'd107374182,
    30'd34359738,  30'd15618063,  30'd1620742
  };

  typedef struct packed {
    logic diff_en;
    logic mul_en;
    logic sum_en;
  } lerp_en_t;

  function automatic logic [DIST_W-1:0] bp_fixed(input logic [SEG_W-1:0] idx);
    return DIST_W'({BP_WHOLE[idx], {DIST_FRAC_BITS{1'b0}}});
  endfunction

endpackage

// ===== rtl/ati_lerp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ati_lerp: three-stage blend of one coefficient column
// Stage A takes the segment's end values and their distance, stage B scales
// that distance by t, stage C rounds and adds or subtracts from the start.
// ----------------------------------------------------------------------------
module ati_lerp (
  input  logic                              clk,
  input  ati_pkg::lerp_en_t                 en,
  input  ati_pkg::coef_col_t                col,
  input  logic [ati_pkg::SEG_W-1:0]         seg,
  input  logic [ati_pkg::T_W-1:0]           t,
  output logic [ati_pkg::COEF_W-1:0]        result
);

  logic [ati_pkg::SEG_W-1:0]  seg_p1;
  logic [ati_pkg::COEF_W-1:0] c0, c1;
  logic [ati_pkg::MUL_W-1:0]  mul;
  logic [ati_pkg::MUL_W:0]    mul_rnd;
  logic [ati_pkg::COEF_W-1:0] step;

  logic [ati_pkg::COEF_W-1:0] c0_a_r, delta_a_r;
  logic                       down_a_r;
  logic [ati_pkg::COEF_W-1:0] c0_b_r;
  logic                       down_b_r;
  logic [ati_pkg::MUL_W-1:0]  mul_b_r;
  logic [ati_pkg::COEF_W-1:0] result_r;

  assign seg_p1 = seg + ati_pkg::SEG_W'(1);
  assign c0     = ati_pkg::COEF_Q[seg][col];
  assign c1     = ati_pkg::COEF_Q[seg_p1][col];

  always_ff @(posedge clk) begin
    if (en.diff_en) begin
      c0_a_r    <= c0;
      down_a_r  <= (c1 < c0);
      delta_a_r <= (c1 < c0) ? (c0 - c1) : (c1 - c0);
    end
  end

  assign mul = delta_a_r * t;

  always_ff @(posedge clk) begin
    if (en.mul_en) begin
      c0_b_r   <= c0_a_r;
      down_b_r <= down_a_r;
      mul_b_r  <= mul;
    end
  end

  // step never exceeds the delta, so the result stays between the two rows
  assign mul_rnd = {1'b0, mul_b_r} + ((ati_pkg::MUL_W + 1)'(1) << (ati_pkg::T_BITS - 1));
  assign step    = mul_rnd[ati_pkg::T_BITS +: ati_pkg::COEF_W];

  always_ff @(posedge clk) begin
    if (en.sum_en) begin
      result_r <= down_b_r ? (c0_b_r - step) : (c0_b_r + step);
    end
  end

  assign result = result_r;

endmodule

// ===== rtl/attenuation_table_interpolator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// attenuation_table_interpolator_top: light range to attenuation coefficients
// Maps a 12.8 distance to constant, linear and quadratic Q1.30 terms by
// piecewise linear interpolation over a fixed 12-row breakpoint table.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid / in_stall / in_range_distance carries one request
//   per distance. Output channel out_valid / out_stall / out_coef_* returns
//   exactly one result per request, in order.
//   Throughput is one request per cycle while out_stall is low: six register
//   stages (segment search, offset, reciprocal multiply, t rounding,
//   coefficient multiply, blend), each with its own valid bit.
//   A stall on the output holds the output register; stages behind it keep
//   filling empty slots, and in_stall rises only once every stage is full.
//   Distances at or below the first breakpoint give the first row, at or
//   above the last breakpoint the last row.
//   Reset (rst_n low, synchronous) empties the pipeline; no clearing pass.
// ----------------------------------------------------------------------------
module attenuation_table_interpolator_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ati_pkg::DIST_W-1:0]    in_range_distance,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ati_pkg::COEF_W-1:0]    out_coef_constant,
  output logic [ati_pkg::COEF_W-1:0]    out_coef_linear,
  output logic [ati_pkg::COEF_W-1:0]    out_coef_quadratic
);

  localparam int STAGES = 6;

  logic [STAGES-1:0] vld_r, vld_nxt;
  logic [STAGES-1:0] en;

  // stage 1: segment search
  logic [ati_pkg::SEG_W-1:0]  seg_cnt;
  logic [ati_pkg::DIST_W-1:0] d1_r;
  logic [ati_pkg::SEG_W-1:0]  seg1_r;
  logic                       lo1_r, hi1_r;
  // stage 2: offset into segment
  logic [ati_pkg::DIST_W-1:0] e2_r;
  logic [ati_pkg::SEG_W-1:0]  seg2_r;
  logic                       hi2_r;
  // stage 3: offset times reciprocal
  logic [ati_pkg::DIST_W+ati_pkg::RECIP_W-1:0] prod_full;
  logic [ati_pkg::PROD_W-1:0] prod3_r;
  logic [ati_pkg::SEG_W-1:0]  seg3_r;
  logic                       hi3_r;
  // stage 4: rounded, capped t
  logic [ati_pkg::PROD_W:0]   prod_rnd;
  logic [ati_pkg::PROD_W-ati_pkg::DIST_FRAC_BITS-8:0] t_raw;
  logic [ati_pkg::T_W-1:0]    t4_r;

  ati_pkg::lerp_en_t lerp_en;

  always_comb begin
    en[STAGES-1] = !vld_r[STAGES-1] || !out_stall;
    for (int i = STAGES - 2; i >= 0; i--) begin
      en[i] = !vld_r[i] || en[i+1];
    end
  end

  assign in_stall = !en[0];

  always_comb begin
    vld_nxt[0] = en[0] ? in_valid : vld_r[0];
    for (int i = 1; i < STAGES; i++) begin
      if (en[i]) begin
        vld_nxt[i] = vld_r[i-1];
      end else begin
        vld_nxt[i] = vld_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // breakpoints ascend, so the segment is the count of inner ones passed
  always_comb begin
    seg_cnt = '0;
    for (int i = 1; i < ati_pkg::ROWS - 1; i++) begin
      if (in_range_distance >= ati_pkg::bp_fixed(ati_pkg::SEG_W'(i))) begin
        seg_cnt = seg_cnt + ati_pkg::SEG_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      d1_r   <= in_range_distance;
      seg1_r <= seg_cnt;
      lo1_r  <= (in_range_distance <= ati_pkg::bp_fixed('0));
      hi1_r  <= (in_range_distance >=
                 ati_pkg::bp_fixed(ati_pkg::SEG_W'(ati_pkg::ROWS - 1)));
    end
  end

  // below the table: zero offset gives t = 0 on the first segment
  always_ff @(posedge clk) begin
    if (en[1]) begin
      e2_r   <= lo1_r ? '0 : (d1_r - ati_pkg::bp_fixed(seg1_r));
      seg2_r <= seg1_r;
      hi2_r  <= hi1_r;
    end
  end

  assign prod_full = e2_r * ati_pkg::RECIP[seg2_r];

  always_ff @(posedge clk) begin
    if (en[2]) begin
      prod3_r <= prod_full[ati_pkg::PROD_W-1:0];
      seg3_r  <= seg2_r;
      hi3_r   <= hi2_r;
    end
  end

  assign prod_rnd = {1'b0, prod3_r} +
                    ((ati_pkg::PROD_W + 1)'(1) << (ati_pkg::DIST_FRAC_BITS + 7));
  assign t_raw    = prod_rnd[ati_pkg::PROD_W:ati_pkg::DIST_FRAC_BITS+8];

  // beyond the table: t = 1 on the last segment lands on the last row
  always_ff @(posedge clk) begin
    if (en[3]) begin
      if (hi3_r || (t_raw > ($bits(t_raw))'(ati_pkg::T_ONE))) begin
        t4_r <= ati_pkg::T_ONE;
      end else begin
        t4_r <= t_raw[ati_pkg::T_W-1:0];
      end
    end
  end

  assign lerp_en.diff_en = en[3];
  assign lerp_en.mul_en  = en[4];
  assign lerp_en.sum_en  = en[5];

  ati_lerp u_lerp_const (
    .clk    (clk),
    .en     (lerp_en),
    .col    (ati_pkg::COL_CONST),
    .seg    (seg3_r),
    .t      (t4_r),
    .result (out_coef_constant)
  );

  ati_lerp u_lerp_lin (
    .clk    (clk),
    .en     (lerp_en),
    .col    (ati_pkg::COL_LIN),
    .seg    (seg3_r),
    .t      (t4_r),
    .result (out_coef_linear)
  );

  ati_lerp u_lerp_quad (
    .clk    (clk),
    .en     (lerp_en),
    .col    (ati_pkg::COL_QUAD),
    .seg    (seg3_r),
    .t      (t4_r),
    .result (out_coef_quadratic)
  );

  assign out_valid = vld_r[STAGES-1];

endmodule

// ===== rtl/ati_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ati_checker: port-level checks for the attenuation table interpolator
// Watches reset, output and input hold under stall, back-pressure and the constant term.
// ----------------------------------------------------------------------------
module ati_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [ati_pkg::DIST_W-1:0]    in_range_distance,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [ati_pkg::COEF_W-1:0]    out_coef_constant,
  input  logic [ati_pkg::COEF_W-1:0]    out_coef_linear,
  input  logic [ati_pkg::COEF_W-1:0]    out_coef_quadratic
);

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid set right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_coef_constant) &&
                               $stable(out_coef_linear) && $stable(out_coef_quadratic))
    else $error("stalled result changed or dropped");

  // input back-pressure only comes from a stalled, full output
  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("in_stall without output stall");

  // every table row has a constant term of one
  a_const_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_coef_constant == ati_pkg::COEF_ONE)
    else $error("constant term differs from one");

  // request held while stalled with a valid in flight, upstream side
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_range_distance))
    else $error("stalled request changed");

endmodule

bind attenuation_table_interpolator_top ati_checker u_ati_checker (.*);
